// ===== rtl/hvst_pkg.sv =====
// hvst_pkg: sizes, codes, state type and helper functions of the viterbi tagger
// used by hmm_viterbi_segment_tagger_top; no dependencies
`timescale 1ns / 1ps

package hvst_pkg;

    localparam int TAG_W       = 5;
    localparam int NUM_TAGS    = 1 << TAG_W;
    localparam int CLS_W       = 8;
    localparam int NUM_CLASSES = 1 << CLS_W;
    localparam int SEG_W       = 6;
    localparam int MAX_SEGMENT = 1 << SEG_W;
    localparam int SEGLEN_W    = SEG_W + 1;
    localparam int COST_W      = 16;
    localparam int SCORE_W     = 24;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [COST_W-1:0]  COST_IMP  = {COST_W{1'b1}};

    localparam logic [1:0] CMD_WORD  = 2'd0;
    localparam logic [1:0] CMD_TRANS = 2'd1;
    localparam logic [1:0] CMD_EMIS  = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_EMPTY    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RUN   = 8'b0000_0010,
        ST_DRAIN = 8'b0000_0100,
        ST_FIN   = 8'b0000_1000,
        ST_TRACE = 8'b0001_0000,
        ST_ERD   = 8'b0010_0000,
        ST_EWR   = 8'b0100_0000,
        ST_ERR   = 8'b1000_0000
    } t_state;

    // index of the lowest set bit, zero for an empty mask
    function automatic logic [TAG_W-1:0] lowest_idx(input logic [NUM_TAGS-1:0] m);
        logic [TAG_W-1:0] r;
        r = '0;
        for (int k = NUM_TAGS - 1; k >= 0; k--) begin
            if (m[k]) r = TAG_W'(k);
        end
        return r;
    endfunction

    // previous score plus transition and emission cost, saturating
    function automatic logic [SCORE_W-1:0] cand(input logic [SCORE_W-1:0] p,
                                                input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
        logic [SCORE_W+1:0] s;
        s = {2'b00, p} + (SCORE_W+2)'(a) + (SCORE_W+2)'(b);
        if (p == SCORE_MAX || a == COST_IMP || b == COST_IMP) return SCORE_MAX;
        if (s > (SCORE_W+2)'(SCORE_MAX)) return SCORE_MAX;
        return s[SCORE_W-1:0];
    endfunction

endpackage

// ===== rtl/hmm_viterbi_segment_tagger_top.sv =====
// hmm_viterbi_segment_tagger_top: first-order hmm viterbi tagger, cost tables,
// score banks, backpointers and path buffer in on-chip memories; uses hvst_pkg
`timescale 1ns / 1ps

// usage
//  s channel: one request per cycle at most, taken only in idle; tdata packs cmd,
//   tag_set, from_tag, to_tag, class_index and cost; a cost load leaves it idle.
//  a word with tag sets of a and p bits (p = previous word's set) walks every
//   current/previous tag pair through one shared adder and compare, one pair a
//   cycle; a single-tag word closes the segment and adds a backpointer
//   traceback over the n+1 words of the segment and a path buffer read ahead
//   of each emitted result (path buffer read port)
//  m channel: one request per word of the closed segment, tlast on the final
//   one, tuser carries the error code; empty tag set or overflow gives one
//   error request with tlast set
//  the result register keeps its request while the receiver stalls; the block
//   then waits before issuing the next one, but returns to idle behind the
//   final request and takes new input
//  cfg channel: always ready, writes start_tag; re-anchors when no word is
//   pending
//  reset: start tag 0 anchors the first segment; cost tables and backpointers
//   hold nothing until written, no clearing pass
module hmm_viterbi_segment_tagger_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0] tag_set[33:2] from_tag[38:34] to_tag[43:39] class_index[51:44]
    // cost[67:52], zero fill above
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // position[5:0] tag[10:6], zero fill above
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // error[1:0]
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    localparam int TW = hvst_pkg::TAG_W;
    localparam int NT = hvst_pkg::NUM_TAGS;
    localparam int CW = hvst_pkg::CLS_W;
    localparam int SW = hvst_pkg::SEG_W;
    localparam int LW = hvst_pkg::SEGLEN_W;
    localparam int KW = hvst_pkg::COST_W;
    localparam int PW = hvst_pkg::SCORE_W;

    // input fields
    logic [1:0]    in_cmd;
    logic [NT-1:0] in_ts;
    logic [TW-1:0] in_from, in_to;
    logic [CW-1:0] in_cls;
    logic [KW-1:0] in_cost;
    assign in_cmd  = s_axis_tdata[1:0];
    assign in_ts   = s_axis_tdata[33:2];
    assign in_from = s_axis_tdata[38:34];
    assign in_to   = s_axis_tdata[43:39];
    assign in_cls  = s_axis_tdata[51:44];
    assign in_cost = s_axis_tdata[67:52];

    // memories
    logic [KW-1:0] trans_mem [NT*NT];
    logic [KW-1:0] emis_mem  [NT*hvst_pkg::NUM_CLASSES];
    logic [PW-1:0] score_mem [2*NT];
    logic [TW-1:0] bp_mem    [hvst_pkg::MAX_SEGMENT*NT];
    logic [TW-1:0] path_mem  [hvst_pkg::MAX_SEGMENT];

    hvst_pkg::t_state r_state;

    // segment state
    logic [TW-1:0] r_start;
    logic [NT-1:0] r_prev_set;
    logic [LW-1:0] r_seglen;
    logic          r_bank;
    logic          r_anchored;   // previous scores are zero at the anchor tag

    // current word
    logic [NT-1:0] r_ts, r_imask, r_jmask;
    logic [CW-1:0] r_cls;
    logic [TW-1:0] r_only;
    logic          r_single;
    logic [1:0]    r_err;

    // pair issue
    logic [TW-1:0] a_i, a_j;
    logic          a_first, a_last_j, a_done;
    assign a_i      = hvst_pkg::lowest_idx(r_imask);
    assign a_j      = hvst_pkg::lowest_idx(r_jmask);
    assign a_last_j = ((r_jmask & (r_jmask - NT'(1))) == '0);
    assign a_first  = (r_jmask == r_prev_set);
    assign a_done   = a_last_j && ((r_imask & (r_imask - NT'(1))) == '0);

    // compare stage
    logic          r_b_valid, r_b_first, r_b_last;
    logic [TW-1:0] r_b_i, r_b_j;
    logic [KW-1:0] r_tr_rd, r_em_rd;
    logic [PW-1:0] r_sc_rd, r_best;
    logic [TW-1:0] r_bp;
    logic [PW-1:0] b_prev, b_c, b_best_in, n_best;
    logic [TW-1:0] b_bp_in, n_bp;

    assign b_prev    = r_anchored ? '0 : r_sc_rd;
    assign b_c       = hvst_pkg::cand(b_prev, r_tr_rd, r_em_rd);
    assign b_best_in = r_b_first ? hvst_pkg::SCORE_MAX : r_best;
    assign b_bp_in   = r_b_first ? '0 : r_bp;
    always_comb begin
        n_best = b_best_in;
        n_bp   = b_bp_in;
        // later predecessor wins ties
        if (b_c <= b_best_in) begin
            n_best = b_c;
            n_bp   = r_b_j;
        end
    end

    // traceback and emit
    logic [SW-1:0] r_tpos, r_pos, r_k;
    logic          r_tfirst;
    logic [TW-1:0] r_bp_rd, r_path_rd, t_tag;
    assign t_tag = r_tfirst ? r_only : r_bp_rd;

    // result register
    logic          r_ov, r_o_last;
    logic [SW-1:0] r_o_pos;
    logic [TW-1:0] r_o_tag;
    logic [1:0]    r_o_err;
    logic          out_free;
    assign out_free = !r_ov || m_axis_tready;

    assign s_axis_tready = (r_state == hvst_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'd0, r_o_tag, r_o_pos};
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_err;

    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    // cost tables: loaded in idle, read by the pair issue
    always_ff @(posedge i_clk) begin
        if (acc && in_cmd == hvst_pkg::CMD_TRANS) trans_mem[{in_from, in_to}] <= in_cost;
        r_tr_rd <= trans_mem[{a_j, a_i}];
    end

    always_ff @(posedge i_clk) begin
        if (acc && in_cmd == hvst_pkg::CMD_EMIS) emis_mem[{in_to, in_cls}] <= in_cost;
        r_em_rd <= emis_mem[{a_i, r_cls}];
    end

    // score banks: read previous bank, write current bank
    always_ff @(posedge i_clk) begin
        if (r_b_valid && r_b_last) score_mem[{~r_bank, r_b_i}] <= n_best;
        r_sc_rd <= score_mem[{r_bank, a_j}];
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid && r_b_last) bp_mem[{r_seglen[SW-1:0], r_b_i}] <= n_bp;
        r_bp_rd <= bp_mem[{r_tpos, t_tag}];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hvst_pkg::ST_TRACE) path_mem[r_tpos] <= t_tag;
        r_path_rd <= path_mem[r_k];
    end

    // payload of the compare stage
    always_ff @(posedge i_clk) begin
        r_b_i     <= a_i;
        r_b_j     <= a_j;
        r_b_first <= a_first;
        r_b_last  <= a_last_j;
        if (r_b_valid) begin
            r_best <= n_best;
            r_bp   <= n_bp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= hvst_pkg::ST_IDLE;
            r_start    <= '0;
            r_prev_set <= NT'(1);
            r_seglen   <= '0;
            r_bank     <= 1'b0;
            r_anchored <= 1'b1;
            r_b_valid  <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_b_valid <= 1'b0;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;

            if (i_cfg_valid) begin
                r_start <= i_cfg_data;
                if (r_seglen == '0) begin
                    r_prev_set <= NT'(1) << i_cfg_data;
                    r_anchored <= 1'b1;
                end
            end

            unique case (r_state)
                hvst_pkg::ST_IDLE: begin
                    if (acc && in_cmd == hvst_pkg::CMD_WORD) begin
                        r_ts     <= in_ts;
                        r_imask  <= in_ts;
                        r_jmask  <= r_prev_set;
                        r_cls    <= in_cls;
                        r_only   <= hvst_pkg::lowest_idx(in_ts);
                        r_single <= ((in_ts & (in_ts - NT'(1))) == '0);
                        if (in_ts == '0) begin
                            r_err   <= hvst_pkg::ERR_EMPTY;
                            r_state <= hvst_pkg::ST_ERR;
                        end else if (r_seglen >= LW'(hvst_pkg::MAX_SEGMENT)) begin
                            // drop the pending segment, re-anchor at start
                            r_err      <= hvst_pkg::ERR_OVERFLOW;
                            r_prev_set <= NT'(1) << r_start;
                            r_anchored <= 1'b1;
                            r_seglen   <= '0;
                            r_state    <= hvst_pkg::ST_ERR;
                        end else begin
                            r_state <= hvst_pkg::ST_RUN;
                        end
                    end
                end
                hvst_pkg::ST_RUN: begin
                    r_b_valid <= 1'b1;
                    if (a_last_j) begin
                        r_imask <= r_imask & (r_imask - NT'(1));
                        r_jmask <= r_prev_set;
                    end else begin
                        r_jmask <= r_jmask & (r_jmask - NT'(1));
                    end
                    if (a_done) r_state <= hvst_pkg::ST_DRAIN;
                end
                hvst_pkg::ST_DRAIN: begin
                    r_state <= hvst_pkg::ST_FIN;
                end
                hvst_pkg::ST_FIN: begin
                    r_prev_set <= r_ts;
                    r_bank     <= ~r_bank;
                    r_tpos     <= r_seglen[SW-1:0];
                    r_pos      <= r_seglen[SW-1:0];
                    r_tfirst   <= 1'b1;
                    if (r_single) begin
                        // closing tag anchors the next segment at score zero
                        r_anchored <= 1'b1;
                        r_seglen   <= '0;
                        r_state    <= hvst_pkg::ST_TRACE;
                    end else begin
                        r_anchored <= 1'b0;
                        r_seglen   <= r_seglen + LW'(1);
                        r_state    <= hvst_pkg::ST_IDLE;
                    end
                end
                hvst_pkg::ST_TRACE: begin
                    r_tfirst <= 1'b0;
                    if (r_tpos == '0) begin
                        r_k     <= '0;
                        r_state <= hvst_pkg::ST_ERD;
                    end else begin
                        r_tpos <= r_tpos - SW'(1);
                    end
                end
                hvst_pkg::ST_ERD: begin
                    r_state <= hvst_pkg::ST_EWR;
                end
                hvst_pkg::ST_EWR: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_o_pos  <= r_k;
                        r_o_tag  <= r_path_rd;
                        r_o_last <= (r_k == r_pos);
                        r_o_err  <= hvst_pkg::ERR_NONE;
                        if (r_k == r_pos) begin
                            r_state <= hvst_pkg::ST_IDLE;
                        end else begin
                            r_k     <= r_k + SW'(1);
                            r_state <= hvst_pkg::ST_ERD;
                        end
                    end
                end
                hvst_pkg::ST_ERR: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_o_pos  <= '0;
                        r_o_tag  <= '0;
                        r_o_last <= 1'b1;
                        r_o_err  <= r_err;
                        r_state  <= hvst_pkg::ST_IDLE;
                    end
                end
                default: r_state <= hvst_pkg::ST_IDLE;
            endcase
        end
    end

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for hmm_viterbi_segment_tagger_top, with a
// scoreboard class that predicts the tagged segments; uses hvst_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
    import hvst_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct {
        logic [1:0]        cmd;
        logic [31:0]       tag_set;
        logic [TAG_W-1:0]  from_tag;
        logic [TAG_W-1:0]  to_tag;
        logic [CLS_W-1:0]  class_index;
        logic [COST_W-1:0] cost;
    } request_t;

    typedef struct {
        logic [SEG_W-1:0] position;
        logic [TAG_W-1:0] tag;
        logic             is_last;
        logic [1:0]       error;
    } tagged_word_t;

    // predicts the tag path of each closed segment and holds the words still due
    class tagger_scoreboard;
        logic [COST_W-1:0]  trans_cost [NUM_TAGS*NUM_TAGS];
        logic [COST_W-1:0]  emis_cost [NUM_TAGS*NUM_CLASSES];
        logic [SCORE_W-1:0] score_bank [2][NUM_TAGS];
        logic [TAG_W-1:0]   back_ptr [MAX_SEGMENT*NUM_TAGS];
        logic [31:0]        prev_set;
        int                 seg_len;
        bit                 bank;
        logic [TAG_W-1:0]   start_tag;
        tagged_word_t       words_due [$];
        int                 failures;

        function void anchor();
            for (int i = 0; i < NUM_TAGS; i++) score_bank[bank][i] = SCORE_MAX;
            score_bank[bank][start_tag] = '0;
            prev_set = 32'd1 << start_tag;
            seg_len = 0;
        endfunction

        function void reset_state();
            failures = 0;
            start_tag = '0;
            bank = 0;
            for (int i = 0; i < NUM_TAGS; i++) score_bank[1][i] = SCORE_MAX;
            anchor();
        endfunction

        function void set_start(logic [TAG_W-1:0] v);
            start_tag = v;
            if (seg_len == 0) anchor();
        endfunction

        function logic [SCORE_W-1:0] path_cost(logic [SCORE_W-1:0] p,
                                               logic [COST_W-1:0] a,
                                               logic [COST_W-1:0] b);
            logic [SCORE_W+1:0] sum;
            if (p == SCORE_MAX || a == COST_IMP || b == COST_IMP) return SCORE_MAX;
            sum = {2'b00, p} + (SCORE_W+2)'(a) + (SCORE_W+2)'(b);
            return (sum > (SCORE_W+2)'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];
        endfunction

        function void add_word(int pos, int tag, bit lst, logic [1:0] err);
            tagged_word_t w;
            w.position = SEG_W'(pos);
            w.tag = TAG_W'(tag);
            w.is_last = lst;
            w.error = err;
            words_due.insert(words_due.size(), w);
        endfunction

        function void note_request(request_t r);
            bit                 cur;
            int                 pos;
            int                 only;
            logic [SCORE_W-1:0] best;
            logic [SCORE_W-1:0] c;
            logic [TAG_W-1:0]   bp;
            logic [COST_W-1:0]  emis;
            int                 path [MAX_SEGMENT];
            if (r.cmd == CMD_TRANS) begin
                trans_cost[{r.from_tag, r.to_tag}] = r.cost;
            end else if (r.cmd == CMD_EMIS) begin
                emis_cost[{r.to_tag, r.class_index}] = r.cost;
            end else if (r.cmd == CMD_WORD) begin
                if (r.tag_set == 0) begin
                    add_word(0, 0, 1, ERR_EMPTY);
                    return;
                end
                if (seg_len >= MAX_SEGMENT) begin
                    anchor();
                    add_word(0, 0, 1, ERR_OVERFLOW);
                    return;
                end
                cur = ~bank;
                pos = seg_len;
                only = 0;
                for (int i = 0; i < NUM_TAGS; i++) begin
                    if (!r.tag_set[i]) begin
                        score_bank[cur][i] = SCORE_MAX;
                        continue;
                    end
                    only = i;
                    emis = emis_cost[{i[TAG_W-1:0], r.class_index}];
                    best = SCORE_MAX;
                    bp = '0;
                    for (int j = 0; j < NUM_TAGS; j++) begin
                        if (!prev_set[j]) continue;
                        c = path_cost(score_bank[bank][j],
                                      trans_cost[{j[TAG_W-1:0], i[TAG_W-1:0]}], emis);
                        // ties go to the later predecessor
                        if (c <= best) begin
                            best = c;
                            bp = j[TAG_W-1:0];
                        end
                    end
                    score_bank[cur][i] = best;
                    back_ptr[pos*NUM_TAGS + i] = bp;
                end
                seg_len = pos + 1;
                prev_set = r.tag_set;
                bank = cur;
                if ($countones(r.tag_set) != 1) return;
                path[pos] = only;
                for (int i = pos; i > 0; i--)
                    path[i-1] = int'(back_ptr[i*NUM_TAGS + path[i]]);
                for (int k = 0; k <= pos; k++) add_word(k, path[k], k == pos, ERR_NONE);
                score_bank[cur][only] = '0;
                seg_len = 0;
            end
        endfunction

        function void check_result(tagged_word_t got);
            tagged_word_t want;
            if (words_due.size() == 0) begin
                $error("unexpected result pos %0d tag %0d", got.position, got.tag);
                failures++;
                return;
            end
            want = words_due.pop_front();
            if (got.position !== want.position) begin
                $error("position: expected %0d actual %0d", want.position, got.position);
                failures++;
            end
            if (got.tag !== want.tag) begin
                $error("tag: expected %0d actual %0d", want.tag, got.tag);
                failures++;
            end
            if (got.is_last !== want.is_last) begin
                $error("last: expected %0d actual %0d", want.is_last, got.is_last);
                failures++;
            end
            if (got.error !== want.error) begin
                $error("error: expected %0d actual %0d", want.error, got.error);
                failures++;
            end
        endfunction

        function void report_leftover();
            if (words_due.size() != 0) begin
                $error("%0d results never arrived", words_due.size());
                failures++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;

    tagger_scoreboard tagger_sb = new();
    bit quiet_phase = 0;   // no idling on either side
    bit hold_request = 0;  // receiver to hold off for a long stretch
    int loaded_classes [5] = '{0, 3, 7, 248, 255};

    hmm_viterbi_segment_tagger_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // hard stop in case the block hangs
    initial begin
        #100_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // tags the words use: 0 to 7 and 31, so every cost that a word reads is loaded
    function automatic int used_tag(input int k);
        return (k == 8) ? NUM_TAGS - 1 : k;
    endfunction

    // one request into the s channel, with an optional random gap afterwards
    task automatic send_request(input request_t r, input bit gaps);
        int gap;
        s_axis_tdata <= {4'b0, r.cost, r.class_index, r.to_tag, r.from_tag,
                         r.tag_set, r.cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        tagger_sb.note_request(r);
        gap = 0;
        if (gaps && !quiet_phase && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_word(input logic [31:0] ts, input logic [7:0] cls, input bit gaps);
        request_t r;
        r = '{CMD_WORD, ts, TAG_W'($urandom), TAG_W'($urandom), cls, COST_W'($urandom)};
        send_request(r, gaps);
    endtask

    task automatic send_load(input logic [1:0] cmd, input int from_t, input int to_t,
                             input int cls, input logic [15:0] cost, input bit gaps);
        request_t r;
        r = '{cmd, $urandom, from_t[TAG_W-1:0], to_t[TAG_W-1:0], cls[CLS_W-1:0], cost};
        send_request(r, gaps);
    endtask

    // sender pauses until every result has come and the block has settled
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tagger_sb.words_due.size() != 0) @(posedge i_clk);
        // a word that closes nothing may still be walking its tag pairs
        repeat (1200) @(posedge i_clk);
    endtask

    task automatic write_start_tag(input logic [4:0] v);
        wait_idle();
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        tagger_sb.set_start(v);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] random_cost();
        case ($urandom_range(0, 9))
            0:       return COST_IMP;
            1:       return COST_W'($urandom_range(0, 3));   // ties likely
            2:       return COST_W'($urandom_range(30000, 65534));
            default: return COST_W'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic logic [31:0] random_tag_set(input int n);
        logic [31:0] ts;
        ts = '0;
        for (int k = 0; k < n; k++) ts[used_tag($urandom_range(0, 8))] = 1'b1;
        return ts;
    endfunction

    // receiver: checks each accepted result and stalls at random
    initial begin
        tagged_word_t got;
        int stall_left;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.position = m_axis_tdata[5:0];
                got.tag = m_axis_tdata[10:6];
                got.is_last = m_axis_tlast;
                got.error = m_axis_tuser;
                tagger_sb.check_result(got);
            end
            if (hold_request) begin
                hold_request = 0;
                stall_left = 1500;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                           : $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int n;
        tagger_sb.reset_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the transitions and emission columns that words will read
        quiet_phase = 1;
        for (int f = 0; f < 9; f++)
            for (int t = 0; t < 9; t++)
                send_load(CMD_TRANS, used_tag(f), used_tag(t), $urandom,
                          COST_W'($urandom_range(0, 1500)), 0);
        foreach (loaded_classes[c])
            for (int t = 0; t < 9; t++)
                send_load(CMD_EMIS, $urandom, used_tag(t), loaded_classes[c],
                          COST_W'($urandom_range(0, 1500)), 0);
        quiet_phase = 0;

        // directed part
        write_start_tag(5'd31);
        send_word(32'h8000_00FF, 8'd255, 1);
        send_word(32'h0000_0001, 8'd0, 1);
        send_word(32'h0000_0000, 8'd3, 1);                // empty tag set
        send_load(CMD_NONE, 0, 0, 0, 0, 1);                 // ignored command
        send_load(CMD_EMIS, 0, 5, 3, COST_IMP, 1);
        send_load(CMD_TRANS, 6, 2, 0, COST_IMP, 1);
        send_load(CMD_TRANS, 4, 2, 0, 16'd0, 1);
        send_load(CMD_TRANS, 31, 4, 0, 16'd0, 1);
        send_word(32'h0000_0050, 8'd3, 1);
        send_word(32'h0000_0024, 8'd3, 1);                // every path impossible into tag 5
        send_word(32'h0000_0004, 8'd255, 1);
        write_start_tag(5'd0);
        // a full segment and then one more word overflows
        for (int k = 0; k < MAX_SEGMENT; k++) send_word(32'h8000_0001, 8'd7, 1);
        send_word(32'h0000_0002, 8'd7, 1);
        // the longest segment that still closes
        for (int k = 0; k < MAX_SEGMENT - 1; k++) send_word(32'h0000_0003, 8'd248, 1);
        send_word(32'h0000_0004, 8'd248, 1);

        // long receiver hold while the sender keeps going, so the block backs up
        hold_request = 1;
        for (int k = 0; k < 30; k++)
            send_word(random_tag_set($urandom_range(1, 2)),
                      CLS_W'(loaded_classes[$urandom_range(0, 4)]), 0);
        wait_idle();

        // random part, in phases with different anchor tags
        for (int phase = 0; phase < 5; phase++) begin
            write_start_tag(phase == 0 ? 5'd0 : phase == 1 ? 5'd31 :
                            5'($urandom_range(0, 7)));
            quiet_phase = (phase == 2);
            for (int k = 0; k < 30; k++) begin
                case ($urandom_range(0, 19))
                    0:       send_load(CMD_TRANS, $urandom, $urandom, 0, random_cost(), 1);
                    1:       send_load(CMD_EMIS, 0, $urandom, $urandom, random_cost(), 1);
                    2:       send_word(32'h0, 8'($urandom), 1);
                    3:       send_load(CMD_NONE, $urandom, $urandom, $urandom,
                                       COST_W'($urandom), 1);
                    default: begin
                        n = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 4);
                        send_word(random_tag_set(n),
                                  CLS_W'(loaded_classes[$urandom_range(0, 4)]), 1);
                    end
                endcase
            end
            quiet_phase = 0;
        end

        s_axis_tvalid <= 1'b0;
        while (tagger_sb.words_due.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        tagger_sb.report_leftover();
        if (tagger_sb.failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hvst_pkg.sv
rtl/hmm_viterbi_segment_tagger_top.sv
verif/testbench.sv
